>>> hdl/polygon_point_inclusion_core_macros.svh
`ifndef POLYGON_POINT_INCLUSION_CORE_MACROS_SVH
`define POLYGON_POINT_INCLUSION_CORE_MACROS_SVH

// Same-cycle implication on aclk, off while aresetn is low
`define PPI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on aclk, off while aresetn is low
`define PPI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/ppi_pkg.sv
`timescale 1ns / 1ps

package ppi_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int COORD_BITS   = 16;

    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int RD_W  = CNT_W + 1;

    // stream payload widths, padded to whole bytes
    localparam int IN_BITS  = 4 * COORD_BITS;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 4 + CNT_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t y;
        coord_t x;
    } point_t;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_FEW  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        TURN_ZERO = 2'b00,
        TURN_POS  = 2'b01,
        TURN_NEG  = 2'b10
    } turn_t;

    // true when both signs are nonzero and of opposite direction
    function automatic logic turn_opposite(input turn_t a, input turn_t b);
        return ((a == TURN_POS) && (b == TURN_NEG)) || ((a == TURN_NEG) && (b == TURN_POS));
    endfunction

endpackage

>>> hdl/ppi_ram.sv
`timescale 1ns / 1ps

module ppi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hdl/ppi_turn.sv
`timescale 1ns / 1ps

module ppi_turn (
    input  logic            clk,
    input  ppi_pkg::point_t a,
    input  ppi_pkg::point_t b,
    input  ppi_pkg::point_t c,
    output ppi_pkg::turn_t  sgn
);

    import ppi_pkg::*;

    localparam int D_W = COORD_BITS + 1;
    localparam int P_W = 2 * D_W;
    localparam int S_W = P_W + 1;

    logic signed [D_W-1:0] bax, cay, bay, cax;
    logic signed [P_W-1:0] p1_reg, p2_reg;
    logic signed [S_W-1:0] det;
    turn_t                 sgn_reg;

    // edge vectors, sign extended by one bit
    assign bax = D_W'(b.x) - D_W'(a.x);
    assign cay = D_W'(c.y) - D_W'(a.y);
    assign bay = D_W'(b.y) - D_W'(a.y);
    assign cax = D_W'(c.x) - D_W'(a.x);

    // stage one: cross products
    always_ff @(posedge clk) begin
        p1_reg <= bax * cay;
        p2_reg <= bay * cax;
    end

    // stage two: sign of the exact determinant
    assign det = S_W'(p1_reg) - S_W'(p2_reg);

    always_ff @(posedge clk) begin
        if (det == '0) begin
            sgn_reg <= TURN_ZERO;
        end else if (det[S_W-1]) begin
            sgn_reg <= TURN_NEG;
        end else begin
            sgn_reg <= TURN_POS;
        end
    end

    assign sgn = sgn_reg;

endmodule

>>> hdl/polygon_point_inclusion_core.sv
// Append, clear and opcodes without meaning: result via the S_DONE state and output register;
// next input accepted once the result is loaded (if the result register is free).
// Query with N >= 3 vertices: one vertex read per cycle from the single-port-read vertex RAM
// (N + 2 reads), then the two-stage turn pipeline drains.
// Reset (aresetn low, synchronous) empties the table and drops any pending result;
// vertex RAM contents are left as they are and only written entries are ever read.
`timescale 1ns / 1ps
`include "polygon_point_inclusion_core_macros.svh"

module polygon_point_inclusion_core (
    input  logic                      aclk,
    input  logic                      aresetn,
    // input channel
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [ppi_pkg::IN_W-1:0]  s_tdata,  // coord_x, coord_y, ray_x, ray_y
    input  logic [1:0]                s_tuser,  // opcode
    // result channel
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [ppi_pkg::OUT_W-1:0] m_tdata   // status, is_convex, inside_res, vertex_count
);

    import ppi_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic             in_xfer;
    op_t              in_op;
    point_t           in_q, in_r;

    // read sequencer
    logic [RD_W-1:0]  rd_cnt_reg;
    logic [IDX_W-1:0] addr_reg;
    logic             rd_en, rd_last;
    logic [CNT_W-1:0] addr_inc;
    point_t           ram_rdata;
    logic             ram_we;

    // pipeline tags
    logic             dv_reg, dlast_reg;
    logic             sh_v_reg, sh_last_reg, sh_full_reg;
    logic             t1_v_reg, t1_last_reg, t1_full_reg;
    logic             t2_v_reg, t2_last_reg, t2_full_reg;
    logic [1:0]       fill_reg;

    point_t           win_a_reg, win_b_reg, win_c_reg;
    point_t           q_reg, r_reg;

    turn_t            t_tri, t_lq, t_lr, t_rc;
    turn_t            r_prev_reg;

    // accumulators
    turn_t            conv_sign_reg, inc_sign_reg;
    logic             conv_ok_reg, inc_ok_reg, parity_reg, first_reg;
    logic             conv_ok_next, inc_ok_next, parity_next, hit;
    logic             acc_v, run_end;

    // result
    status_t          res_status_reg;
    logic             res_conv_reg, res_in_reg;
    logic             m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg;
    logic             out_load;

    // input unpacking
    assign s_tready = (state_reg == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign in_op    = op_t'(s_tuser);
    assign in_q.x   = s_tdata[COORD_BITS-1:0];
    assign in_q.y   = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign in_r.x   = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign in_r.y   = s_tdata[4*COORD_BITS-1:3*COORD_BITS];

    assign ram_we   = in_xfer && (in_op == OP_APPEND) && (count_reg < CNT_W'(MAX_VERTICES));

    // read stream: vertices 0 .. N-1, then 0 and 1 again to close the triples
    assign rd_en    = (state_reg == S_RUN) && (rd_cnt_reg < (RD_W'(count_reg) + RD_W'(2)));
    assign rd_last  = (rd_cnt_reg == (RD_W'(count_reg) + RD_W'(1)));
    assign addr_inc = CNT_W'(addr_reg) + CNT_W'(1);

    ppi_ram #(
        .WIDTH ($bits(point_t)),
        .DEPTH (MAX_VERTICES)
    ) u_vtx_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (in_q),
        .re    (rd_en),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    // advance read counter and wrapping address
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            rd_cnt_reg <= '0;
            addr_reg   <= '0;
        end else if (rd_en) begin
            rd_cnt_reg <= rd_cnt_reg + RD_W'(1);
            addr_reg   <= (addr_inc == count_reg) ? '0 : addr_inc[IDX_W-1:0];
        end
    end

    // hold query point and ray end
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            q_reg <= in_q;
            r_reg <= in_r;
        end
    end

    // shift vertex window as read data arrives
    always_ff @(posedge aclk) begin
        if (dv_reg) begin
            win_a_reg <= win_b_reg;
            win_b_reg <= win_c_reg;
            win_c_reg <= ram_rdata;
        end
    end

    // pipeline tags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg   <= 1'b0;
            sh_v_reg <= 1'b0;
            t1_v_reg <= 1'b0;
            t2_v_reg <= 1'b0;
            fill_reg <= '0;
        end else begin
            dv_reg   <= rd_en;
            sh_v_reg <= dv_reg;
            t1_v_reg <= sh_v_reg;
            t2_v_reg <= t1_v_reg;
            if (in_xfer) begin
                fill_reg <= '0;
            end else if (dv_reg && (fill_reg != 2'd3)) begin
                fill_reg <= fill_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        dlast_reg   <= rd_last;
        sh_last_reg <= dlast_reg;
        sh_full_reg <= fill_reg[1];
        t1_last_reg <= sh_last_reg;
        t1_full_reg <= sh_full_reg;
        t2_last_reg <= t1_last_reg;
        t2_full_reg <= t1_full_reg;
    end

    // turn units: vertex triple, edge against Q, edge against R, segment QR against vertex
    ppi_turn u_turn_tri (.clk(aclk), .a(win_a_reg), .b(win_b_reg), .c(win_c_reg), .sgn(t_tri));
    ppi_turn u_turn_lq  (.clk(aclk), .a(win_b_reg), .b(win_c_reg), .c(q_reg),     .sgn(t_lq));
    ppi_turn u_turn_lr  (.clk(aclk), .a(win_b_reg), .b(win_c_reg), .c(r_reg),     .sgn(t_lr));
    ppi_turn u_turn_rc  (.clk(aclk), .a(q_reg),     .b(r_reg),     .c(win_c_reg), .sgn(t_rc));

    // fold one edge into the running flags
    assign acc_v   = t2_v_reg && t2_full_reg;
    assign run_end = t2_v_reg && t2_last_reg;
    assign hit     = turn_opposite(t_lq, t_lr) && turn_opposite(r_prev_reg, t_rc);

    always_comb begin
        conv_ok_next = conv_ok_reg;
        inc_ok_next  = inc_ok_reg;
        parity_next  = parity_reg;
        if (acc_v) begin
            parity_next = parity_reg ^ hit;
            if (!first_reg) begin
                conv_ok_next = conv_ok_reg && (t_tri == conv_sign_reg);
                inc_ok_next  = inc_ok_reg && (t_lq == inc_sign_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (t2_v_reg) begin
            r_prev_reg <= t_rc;
        end
        if (in_xfer) begin
            first_reg   <= 1'b1;
            conv_ok_reg <= 1'b1;
            inc_ok_reg  <= 1'b1;
            parity_reg  <= 1'b0;
        end else if (acc_v) begin
            first_reg   <= 1'b0;
            conv_ok_reg <= conv_ok_next;
            inc_ok_reg  <= inc_ok_next;
            parity_reg  <= parity_next;
            if (first_reg) begin
                conv_sign_reg <= t_tri;
                inc_sign_reg  <= t_lq;
            end
        end
    end

    // control: state and vertex count
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_xfer) begin
                    case (in_op)
                        OP_APPEND: begin
                            if (ram_we) begin
                                count_next = count_reg + CNT_W'(1);
                            end
                            state_next = S_DONE;
                        end
                        OP_QUERY: begin
                            state_next = (count_reg < CNT_W'(3)) ? S_DONE : S_RUN;
                        end
                        OP_CLEAR: begin
                            count_next = '0;
                            state_next = S_DONE;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_RUN: begin
                if (run_end) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // result fields for the current item
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            res_conv_reg <= 1'b0;
            res_in_reg   <= 1'b0;
            if ((in_op == OP_APPEND) && !ram_we) begin
                res_status_reg <= ST_FULL;
            end else if ((in_op == OP_QUERY) && (count_reg < CNT_W'(3))) begin
                res_status_reg <= ST_FEW;
            end else begin
                res_status_reg <= ST_OK;
            end
        end else if ((state_reg == S_RUN) && run_end) begin
            res_conv_reg <= conv_ok_next;
            res_in_reg   <= conv_ok_next ? inc_ok_next : parity_next;
        end
    end

    // output register: load when empty or being drained
    assign out_load = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= OUT_W'({count_reg, res_in_reg, res_conv_reg, res_status_reg});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // checks
    `PPI_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_VERTICES), "vertex count overflow")
    `PPI_ASSERT_NOW(a_read_in_table, rd_en, CNT_W'(addr_reg) < count_reg, "read beyond stored vertices")
    `PPI_ASSERT_NOW(a_result_in_run, t2_v_reg, state_reg == S_RUN, "turn result outside a query")
    `PPI_ASSERT_NEXT(a_out_loaded, out_load, m_tvalid_reg && (state_reg == S_IDLE), "result not presented")
    `PPI_ASSERT_NEXT(a_full_keeps_count, ram_we == 1'b0 && in_xfer && in_op == OP_APPEND, count_reg == $past(count_reg), "count moved on ignored append")

endmodule
